[hdl/phl_pkg.sv]
// Package for the polyline haversine length block: state and operation codes,
// fixed-point Q40 constants and the CORDIC arctangent table.
// No dependencies.
package phl_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_MUL_END,
      ST_REDUCE,
      ST_ROTATE,
      ST_POST,
      ST_SQRT,
      ST_VECTOR,
      ST_ACCUM,
      ST_OUT
   } state_type;

   // Which trigonometric term the angle path is producing
   typedef enum logic [1:0] {
      JOB_SIN_LAT,
      JOB_SIN_LON,
      JOB_COS_1,
      JOB_COS_2
   } job_type;

   // What a finished product is used for
   typedef enum logic [2:0] {
      MOP_ANGLE,
      MOP_SQ,
      MOP_CC,
      MOP_H,
      MOP_LEN
   } mop_type;

   localparam int FRAC_BITS  = 40;
   localparam int SQRT_STEPS = 42;
   localparam int ATAN_DEPTH = 48;

   localparam logic [63:0] PI_Q62      = 64'hC90F_DAA2_2168_C234;
   localparam logic signed [63:0] PI_Q40 = 64'((PI_Q62 + (64'd1 << 21)) >> 22);
   localparam logic signed [63:0] HALF_PI_Q40 = 64'((PI_Q62 + (64'd1 << 22)) >> 23);
   localparam logic [63:0] UNIT_TO_RAD = (PI_Q62 + 64'd3600000000) / 64'd7200000000;
   localparam logic signed [63:0] GAIN_INV_Q40 = 64'sd667681663043;
   localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
   localparam logic [47:0] SUM_MAX       = 48'hFFFF_FFFF_FFFF;
   localparam logic [26:0] RADIUS_RESET  = 27'd63674475;

   typedef logic signed [63:0] atan_tab_type [0:ATAN_DEPTH-1];

   // Long division by shift and subtract, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q40 from its power series in Q62
   function automatic logic signed [63:0] atan_q(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      acc = '0;
      if (i == 0) return 64'((PI_Q62 + (64'd1 << 23)) >> 24);
      for (int k = 0; k < 32; k++) begin
         if (i * (2 * k + 1) <= 62) begin
            term = udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
         end
      end
      return 64'((acc + (64'd1 << 21)) >> 22);
   endfunction

   function automatic atan_tab_type atan_table();
      atan_tab_type tab;
      for (int i = 0; i < ATAN_DEPTH; i++) tab[i] = atan_q(i);
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = atan_table();

endpackage

[hdl/polyline_haversine_length_top.sv]
// Polyline haversine length: top level with sequencer and shared datapath.
// Depends on phl_pkg.
//
// Vertices of a polyline arrive one per request; each segment after the first
// vertex is measured as a great-circle distance and added, with saturation,
// into a 48-bit sum given out in 1e-4 m on the last vertex. A vertex that opens
// a polyline is only taken, and goes straight to the response when it is also
// the last one. Any other vertex passes through four rotation runs and one
// vectoring run of the CORDIC stage at one iteration a cycle, nine products on
// one 32x32 multiplier at four partial products each, two digit-by-digit square
// roots at one bit a cycle, and the take, start, reduction, post and accumulate
// states. req_tready is low while a vertex is in work or a result waits on the
// response side.
module polyline_haversine_length_top #(
   parameter int CORDIC_ITERATIONS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [30:0] latitude, [62:31] longitude
   input  logic        req_tuser,   // first_point
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [47:0] total_length, [48] saturated
   input  logic        csr_wr_en,
   input  logic [26:0] csr_wr_data  // sphere_radius
);
   import phl_pkg::*;

   localparam int STEP_MAX = (CORDIC_ITERATIONS > SQRT_STEPS) ? CORDIC_ITERATIONS : SQRT_STEPS;
   localparam int STEP_W   = $clog2(STEP_MAX);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   mop_type   mop_ff, mop_in;

   logic [26:0] radius_ff, radius_in;
   logic signed [30:0] prev_lat_ff, prev_lat_in, cur_lat_ff, cur_lat_in;
   logic signed [31:0] prev_lon_ff, prev_lon_in, cur_lon_ff, cur_lon_in;
   logic        last_ff, last_in;
   logic        have_prev_ff, have_prev_in;
   logic [47:0] sum_ff, sum_in;
   logic        sat_ff, sat_in;

   logic [63:0]  mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [127:0] mul_acc_ff, mul_acc_in;
   logic [1:0]   mul_cnt_ff, mul_cnt_in;

   logic signed [63:0] t_ff, t_in, x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [63:0] c1_ff, c1_in, sa2_ff, sa2_in, sb2_ff, sb2_in, h_ff, h_in;
   logic        neg_ff, neg_in, cc_neg_ff, cc_neg_in, sq_sel_ff, sq_sel_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [83:0] sq_n_ff, sq_n_in;
   logic [44:0] sq_rem_ff, sq_rem_in;
   logic [41:0] sq_root_ff, sq_root_in, xv_ff, xv_in;
   logic [63:0] d_ff, d_in;

   // Combinational helpers
   logic        req_take;
   logic        is_sin, reduce_more, last_rot, last_sqrt;
   logic [63:0] mag_lat_d, mag_lon_d, mag_c1, mag_c2;
   logic signed [31:0] dlat;
   logic signed [32:0] dlon;
   logic [127:0] rounded;
   logic [63:0] res;
   logic signed [63:0] xs, ys, atan_i, t_fold, c_val, hp, h_sum, z_clamp;
   logic [44:0] rem2, trial;
   logic [41:0] root_next;
   logic [36:0] rad1000;

   assign req_take  = req_tvalid && req_tready;
   assign is_sin    = (job_ff == JOB_SIN_LAT) || (job_ff == JOB_SIN_LON);
   assign reduce_more = is_sin && (t_ff >= PI_Q40);
   assign last_rot  = step_ff == STEP_W'(CORDIC_ITERATIONS - 1);
   assign last_sqrt = step_ff == STEP_W'(SQRT_STEPS - 1);

   // Angle magnitudes in 1e-7 degree
   assign dlat = 32'(prev_lat_ff) - 32'(cur_lat_ff);
   assign dlon = 33'(prev_lon_ff) - 33'(cur_lon_ff);
   assign mag_lat_d = dlat[31] ? 64'(-dlat) : 64'(dlat);
   assign mag_lon_d = dlon[32] ? 64'(-dlon) : 64'(dlon);
   assign mag_c1 = prev_lat_ff[30] ? 64'(-32'(prev_lat_ff)) : 64'(prev_lat_ff);
   assign mag_c2 = cur_lat_ff[30]  ? 64'(-32'(cur_lat_ff))  : 64'(cur_lat_ff);

   // One partial product per cycle
   logic [63:0] pp_full;
   logic [31:0] pa, pb;
   always_comb begin
      unique case (mul_cnt_ff)
         2'd0: begin pa = mul_a_ff[31:0];  pb = mul_b_ff[31:0];  end
         2'd1: begin pa = mul_a_ff[31:0];  pb = mul_b_ff[63:32]; end
         2'd2: begin pa = mul_a_ff[63:32]; pb = mul_b_ff[31:0];  end
         default: begin pa = mul_a_ff[63:32]; pb = mul_b_ff[63:32]; end
      endcase
      pp_full = pa * pb;
   end

   // Round half up and scale the finished product
   always_comb begin
      if (mop_ff == MOP_ANGLE && is_sin) begin
         rounded = mul_acc_ff + (128'd1 << 20);
         res     = rounded[84:21];
      end else if (mop_ff == MOP_ANGLE) begin
         rounded = mul_acc_ff + (128'd1 << 19);
         res     = rounded[83:20];
      end else begin
         rounded = mul_acc_ff + (128'd1 << (FRAC_BITS - 1));
         res     = rounded[FRAC_BITS+63:FRAC_BITS];
      end
   end

   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign atan_i = ATAN_TAB[step_ff];
   assign t_fold = (t_ff > HALF_PI_Q40) ? PI_Q40 - t_ff : t_ff;
   assign c_val  = neg_ff ? -x_ff : x_ff;
   assign hp     = cc_neg_ff ? -$signed(res) : $signed(res);
   assign h_sum  = sa2_ff + hp;
   assign rem2   = {sq_rem_ff[42:0], sq_n_ff[83:82]};
   assign trial  = {1'b0, sq_root_ff, 2'b01};
   assign root_next = (rem2 >= trial) ? {sq_root_ff[40:0], 1'b1} : {sq_root_ff[40:0], 1'b0};
   assign rad1000 = {radius_ff, 10'b0} - {6'b0, radius_ff, 4'b0} - {7'b0, radius_ff, 3'b0};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser || !have_prev_ff) state_in = req_tlast ? ST_OUT : ST_IDLE;
               else state_in = ST_START;
            end
         end
         ST_START:   state_in = ST_MUL;
         ST_MUL:     if (mul_cnt_ff == 2'd3) state_in = ST_MUL_END;
         ST_MUL_END: begin
            unique case (mop_ff)
               MOP_ANGLE: state_in = ST_REDUCE;
               MOP_H:     state_in = ST_SQRT;
               MOP_LEN:   state_in = ST_ACCUM;
               default:   state_in = ST_MUL;
            endcase
         end
         ST_REDUCE:  if (!reduce_more) state_in = ST_ROTATE;
         ST_ROTATE:  if (last_rot) state_in = ST_POST;
         ST_POST:    state_in = ST_MUL;
         ST_SQRT:    if (last_sqrt && sq_sel_ff) state_in = ST_VECTOR;
         ST_VECTOR:  if (last_rot) state_in = ST_MUL;
         ST_ACCUM:   state_in = last_ff ? ST_OUT : ST_IDLE;
         ST_OUT:     if (rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      rsp_tdata  = {7'b0, sat_ff, sum_ff};
   end

   // Datapath
   always_comb begin
      radius_in = csr_wr_en ? csr_wr_data : radius_ff;
      job_in = job_ff;  mop_in = mop_ff;
      prev_lat_in = prev_lat_ff;  prev_lon_in = prev_lon_ff;
      cur_lat_in = cur_lat_ff;  cur_lon_in = cur_lon_ff;  last_in = last_ff;
      have_prev_in = have_prev_ff;  sum_in = sum_ff;  sat_in = sat_ff;
      mul_a_in = mul_a_ff;  mul_b_in = mul_b_ff;
      mul_acc_in = mul_acc_ff;  mul_cnt_in = mul_cnt_ff;
      t_in = t_ff;  x_in = x_ff;  y_in = y_ff;  z_in = z_ff;
      c1_in = c1_ff;  sa2_in = sa2_ff;  sb2_in = sb2_ff;  h_in = h_ff;
      neg_in = neg_ff;  cc_neg_in = cc_neg_ff;  sq_sel_in = sq_sel_ff;
      step_in = step_ff;  sq_n_in = sq_n_ff;  sq_rem_in = sq_rem_ff;
      sq_root_in = sq_root_ff;  xv_in = xv_ff;  d_in = d_ff;
      z_clamp = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Capture the vertex; open a new polyline where needed
            if (req_take) begin
               cur_lat_in = req_tdata[30:0];
               cur_lon_in = req_tdata[62:31];
               last_in    = req_tlast;
               if (req_tuser || !have_prev_ff) begin
                  sum_in       = '0;
                  sat_in       = 1'b0;
                  prev_lat_in  = req_tdata[30:0];
                  prev_lon_in  = req_tdata[62:31];
                  have_prev_in = !req_tlast;
               end
            end
         end
         ST_START: begin
            job_in = JOB_SIN_LAT;  mop_in = MOP_ANGLE;
            mul_a_in = mag_lat_d;  mul_b_in = UNIT_TO_RAD;
            mul_acc_in = '0;  mul_cnt_in = '0;
         end
         ST_MUL: begin
            // Accumulate one partial product
            unique case (mul_cnt_ff)
               2'd0:    mul_acc_in = mul_acc_ff + {64'b0, pp_full};
               2'd3:    mul_acc_in = mul_acc_ff + {pp_full, 64'b0};
               default: mul_acc_in = mul_acc_ff + {32'b0, pp_full, 32'b0};
            endcase
            mul_cnt_in = mul_cnt_ff + 2'd1;
         end
         ST_MUL_END: begin
            mul_acc_in = '0;  mul_cnt_in = '0;
            unique case (mop_ff)
               MOP_ANGLE: t_in = res;
               MOP_SQ: begin
                  mop_in = MOP_ANGLE;  mul_b_in = UNIT_TO_RAD;
                  if (job_ff == JOB_SIN_LAT) begin
                     sa2_in = res;  job_in = JOB_SIN_LON;  mul_a_in = mag_lon_d;
                  end else begin
                     sb2_in = res;  job_in = JOB_COS_1;  mul_a_in = mag_c1;
                  end
               end
               MOP_CC: begin
                  // |cc| times sin^2(dlon/2); sign of cc kept aside
                  mop_in = MOP_H;  mul_a_in = res;  mul_b_in = sb2_ff;
               end
               MOP_H: begin
                  // Clamp h to [0, 1] and start the root of 1 - h
                  if (h_sum < 0) h_in = '0;
                  else if (h_sum > ONE_Q) h_in = ONE_Q;
                  else h_in = h_sum;
                  sq_n_in = {3'b0, 41'(ONE_Q - ((h_sum < 0) ? 64'sd0 :
                            (h_sum > ONE_Q) ? ONE_Q : h_sum)), 40'b0};
                  sq_rem_in = '0;  sq_root_in = '0;  step_in = '0;  sq_sel_in = 1'b0;
               end
               default: d_in = res;
            endcase
         end
         ST_REDUCE: begin
            // Drop whole turns of pi, then fold into the first quadrant
            if (reduce_more) t_in = t_ff - PI_Q40;
            else begin
               neg_in = (t_ff > HALF_PI_Q40);
               x_in = GAIN_INV_Q40;  y_in = '0;  z_in = t_fold;  step_in = '0;
            end
         end
         ST_ROTATE: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;  y_in = y_ff + xs;  z_in = z_ff - atan_i;
            end else begin
               x_in = x_ff + ys;  y_in = y_ff - xs;  z_in = z_ff + atan_i;
            end
            step_in = step_ff + STEP_W'(1);
         end
         ST_POST: begin
            mul_acc_in = '0;  mul_cnt_in = '0;
            priority if (is_sin) begin
               mop_in = MOP_SQ;
               mul_a_in = y_ff[63] ? 64'(-y_ff) : 64'(y_ff);
               mul_b_in = y_ff[63] ? 64'(-y_ff) : 64'(y_ff);
            end else if (job_ff == JOB_COS_1) begin
               c1_in = c_val;  job_in = JOB_COS_2;  mop_in = MOP_ANGLE;
               mul_a_in = mag_c2;  mul_b_in = UNIT_TO_RAD;
            end else begin
               mop_in = MOP_CC;
               cc_neg_in = c1_ff[63] ^ c_val[63];
               mul_a_in = c1_ff[63] ? 64'(-c1_ff) : 64'(c1_ff);
               mul_b_in = c_val[63] ? 64'(-c_val) : 64'(c_val);
            end
         end
         ST_SQRT: begin
            // One root bit per cycle
            sq_rem_in  = (rem2 >= trial) ? rem2 - trial : rem2;
            sq_root_in = root_next;
            sq_n_in    = {sq_n_ff[81:0], 2'b0};
            step_in    = step_ff + STEP_W'(1);
            if (last_sqrt) begin
               step_in = '0;
               if (!sq_sel_ff) begin
                  xv_in = root_next;  sq_sel_in = 1'b1;
                  sq_n_in = {3'b0, h_ff[40:0], 40'b0};
                  sq_rem_in = '0;  sq_root_in = '0;
               end else begin
                  x_in = 64'(xv_ff);  y_in = 64'(root_next);  z_in = '0;
               end
            end
         end
         ST_VECTOR: begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;  y_in = y_ff - xs;  z_in = z_ff + atan_i;
            end else begin
               x_in = x_ff - ys;  y_in = y_ff + xs;  z_in = z_ff - atan_i;
            end
            step_in = step_ff + STEP_W'(1);
            if (last_rot) begin
               // Length = round(2*angle * radius*1000 / 2^40)
               z_clamp  = (z_in < 0) ? 64'sd0 : z_in;
               mop_in   = MOP_LEN;
               mul_a_in = {z_clamp[62:0], 1'b0};
               mul_b_in = 64'(rad1000);
               mul_acc_in = '0;  mul_cnt_in = '0;
            end
         end
         ST_ACCUM: begin
            // Saturating add, then advance the previous vertex
            if (d_ff >= 64'(SUM_MAX - sum_ff)) begin
               sum_in = SUM_MAX;  sat_in = 1'b1;
            end else begin
               sum_in = sum_ff + d_ff[47:0];
            end
            prev_lat_in  = cur_lat_ff;
            prev_lon_in  = cur_lon_ff;
            have_prev_in = !last_ff;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         prev_lat_ff  <= prev_lat_in;
         prev_lon_ff  <= prev_lon_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         have_prev_ff <= have_prev_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;  mop_ff <= mop_in;
      cur_lat_ff <= cur_lat_in;  cur_lon_ff <= cur_lon_in;  last_ff <= last_in;
      mul_a_ff <= mul_a_in;  mul_b_ff <= mul_b_in;
      mul_acc_ff <= mul_acc_in;  mul_cnt_ff <= mul_cnt_in;
      t_ff <= t_in;  x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;
      c1_ff <= c1_in;  sa2_ff <= sa2_in;  sb2_ff <= sb2_in;  h_ff <= h_in;
      neg_ff <= neg_in;  cc_neg_ff <= cc_neg_in;  sq_sel_ff <= sq_sel_in;
      step_ff <= step_in;  sq_n_ff <= sq_n_in;  sq_rem_ff <= sq_rem_in;
      sq_root_ff <= sq_root_in;  xv_ff <= xv_in;  d_ff <= d_in;
   end

   // Checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while a response waits");
   a_sat_sticks: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (sum_ff == SUM_MAX)) else $error("saturation flag without full sum");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_tuser && have_prev_ff) |=> !req_tready)
      else $error("ready during segment work");
   a_rot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE || state_ff == ST_VECTOR) |->
      (step_ff < STEP_W'(CORDIC_ITERATIONS))) else $error("CORDIC step overrun");

endmodule
